[rtl/cdc_pkg.sv]
package cdc_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DOY_W   = 9;
	localparam int PADDR_W = 3;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	localparam logic REG_MIN_YEAR = 1'b0;
	localparam logic REG_MAX_YEAR = 1'b1;

	localparam logic [YEAR_W-1:0]  RST_MIN_YEAR = YEAR_W'(1);
	localparam logic [YEAR_W-1:0]  RST_MAX_YEAR = YEAR_W'(9999);
	localparam logic [YEAR_W-1:0]  RST_YEAR     = YEAR_W'(2000);
	localparam logic [MONTH_W-1:0] RST_MONTH    = MONTH_W'(1);
	localparam logic [DAY_W-1:0]   RST_DAY      = DAY_W'(1);

	localparam logic [MONTH_W-1:0] LAST_MONTH = MONTH_W'(12);

	// Inverse of 25 modulo 2**14 and the largest product a multiple of 25 can give.
	localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(7209);
	localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(((1 << YEAR_W) - 1) / 25);

	typedef struct packed {
		logic               cmd;
		logic [YEAR_W-1:0]  year_in;
		logic [MONTH_W-1:0] month_in;
		logic [DAY_W-1:0]   day_in;
	} req_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year_out;
		logic [MONTH_W-1:0] month_out;
		logic [DAY_W-1:0]   day_out;
		logic [DOY_W-1:0]   day_of_year;
		logic               leap_out;
		logic               status;
	} rsp_t;

	// A year divisible by 25 maps to at most DIV25_MAX when multiplied by the odd inverse.
	function automatic logic leap_of(input logic [YEAR_W-1:0] y);
		logic [YEAR_W-1:0] p;
		logic              div25;
		p     = YEAR_W'(y * INV25);
		div25 = (p <= DIV25_MAX);
		return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
	endfunction

	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] d;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAY_W'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                   d = DAY_W'(30);
			4'd2:                                      d = leap ? DAY_W'(29) : DAY_W'(28);
			default:                                   d = '0;
		endcase
		return d;
	endfunction

	function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] s;
		case (m)
			4'd1:    s = DOY_W'(0);
			4'd2:    s = DOY_W'(31);
			4'd3:    s = DOY_W'(59);
			4'd4:    s = DOY_W'(90);
			4'd5:    s = DOY_W'(120);
			4'd6:    s = DOY_W'(151);
			4'd7:    s = DOY_W'(181);
			4'd8:    s = DOY_W'(212);
			4'd9:    s = DOY_W'(243);
			4'd10:   s = DOY_W'(273);
			4'd11:   s = DOY_W'(304);
			4'd12:   s = DOY_W'(334);
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

[rtl/calendar_date_counter_top.sv]
// Channel   Direction  Handshake              Word
// req       in         req_valid/req_ready    cdc_pkg::req_t (cmd, year, month, day)
// rsp       out        rsp_valid/rsp_ready    cdc_pkg::rsp_t (date, day of year, leap, status)
// apb       in/out     psel/penable/pwrite    min_year at 0x0, max_year at 0x4
//
// One command per cycle: the stored date and the result register update at the
// edge that accepts a word, so a tick sees the previous command's date directly.
// The result register is the only stage; req_ready drops only while a result
// waits and rsp_ready is low. Reset sets the date to 2000-01-01 and the bounds
// to 1..9999; no clearing pass is needed.
module calendar_date_counter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  cdc_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output cdc_pkg::rsp_t                 rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdc_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import cdc_pkg::*;

	logic [YEAR_W-1:0]  min_year_q, max_year_q;
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DAY_W-1:0]   day_q;
	logic               leap_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               wr_en;
	logic               load_leap;
	logic [DAY_W-1:0]   load_lim;
	logic               load_ok;
	logic [YEAR_W-1:0]  next_year_inc;
	logic               next_year_leap;
	logic [DAY_W-1:0]   cur_lim;
	logic [YEAR_W-1:0]  year_d;
	logic [MONTH_W-1:0] month_d;
	logic [DAY_W-1:0]   day_d;
	logic               leap_d;
	logic               status_d;
	logic [DOY_W-1:0]   doy_d;

	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_MAX_YEAR) ? 32'(max_year_q) : 32'(min_year_q);

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= RST_MIN_YEAR;
			max_year_q <= RST_MAX_YEAR;
		end else if (wr_en) begin
			if (paddr[2] == REG_MIN_YEAR) begin
				min_year_q <= pwdata[YEAR_W-1:0];
			end else begin
				max_year_q <= pwdata[YEAR_W-1:0];
			end
		end
	end

	always_comb begin
		load_leap      = leap_of(req.year_in);
		load_lim       = days_in(req.month_in, load_leap);
		load_ok        = (req.year_in >= min_year_q) && (req.year_in <= max_year_q) &&
		                 (load_lim != '0) && (req.day_in != '0) && (req.day_in <= load_lim);
		next_year_inc  = year_q + YEAR_W'(1);
		next_year_leap = leap_of(next_year_inc);
		cur_lim        = days_in(month_q, leap_q);

		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		leap_d   = leap_q;
		status_d = 1'b0;

		if (req.cmd == CMD_LOAD) begin
			if (load_ok) begin
				year_d  = req.year_in;
				month_d = req.month_in;
				day_d   = req.day_in;
				leap_d  = load_leap;
			end else begin
				status_d = 1'b1;
			end
		end else begin
			if (day_q < cur_lim) begin
				day_d = day_q + DAY_W'(1);
			end else begin
				day_d = RST_DAY;
				if (month_q >= LAST_MONTH) begin
					month_d = RST_MONTH;
					year_d  = next_year_inc;
					leap_d  = next_year_leap;
				end else begin
					month_d = month_q + MONTH_W'(1);
				end
			end
			// The advanced date is kept even when its year falls outside the bounds.
			status_d = !((year_d >= min_year_q) && (year_d <= max_year_q));
		end

		doy_d = DOY_W'(day_d) + month_start(month_d) +
		        DOY_W'(leap_d && (month_d > MONTH_W'(2)) && (month_d <= LAST_MONTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q      <= RST_YEAR;
			month_q     <= RST_MONTH;
			day_q       <= RST_DAY;
			leap_q      <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				year_q      <= year_d;
				month_q     <= month_d;
				day_q       <= day_d;
				leap_q      <= leap_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.year_out    <= year_d;
			rsp_q.month_out   <= month_d;
			rsp_q.day_out     <= day_d;
			rsp_q.day_of_year <= doy_d;
			rsp_q.leap_out    <= leap_d;
			rsp_q.status      <= status_d;
		end
	end

endmodule

[verif/calendar_date_counter_top_tb.sv]
module calendar_date_counter_top_tb;
	import cdc_pkg::*;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;

	calendar_date_counter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Predicted calendar state and year bounds.
	logic [YEAR_W-1:0]  cal_year;
	logic [MONTH_W-1:0] cal_month;
	logic [DAY_W-1:0]   cal_day;
	logic               cal_leap;
	logic [YEAR_W-1:0]  lo_year;
	logic [YEAR_W-1:0]  hi_year;

	rsp_t pending_dates[$];
	rsp_t oldest_date;

	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int bound_settings = 0;
	int send_pct = 0;
	int recv_pct = 0;
	int waited;
	logic rsp_stall = 1'b0;
	event hold_go;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#2000000;
		$display("calendar_date_counter_top_tb: errors");
		$finish;
	end

	function automatic logic is_leap(logic [YEAR_W-1:0] y);
		int v;
		v = y;
		return ((v % 4 == 0) && (v % 100 != 0)) || (v % 400 == 0);
	endfunction

	function automatic int month_length(logic [MONTH_W-1:0] m, logic lp);
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
			4'd4, 4'd6, 4'd9, 4'd11: return 30;
			4'd2: return lp ? 29 : 28;
			default: return 0;
		endcase
	endfunction

	function automatic logic year_fits(logic [YEAR_W-1:0] y);
		return (y >= lo_year) && (y <= hi_year);
	endfunction

	// Applies one command to the predicted date and returns the expected result word.
	function automatic rsp_t calendar_apply(req_t w);
		rsp_t r;
		int   lim;
		int   doy;
		logic lp;
		logic bad;
		bad = 1'b0;
		if (w.cmd == CMD_LOAD) begin
			lp  = is_leap(w.year_in);
			lim = month_length(w.month_in, lp);
			if (year_fits(w.year_in) && lim != 0 && w.day_in >= 1 && w.day_in <= lim) begin
				cal_year  = w.year_in;
				cal_month = w.month_in;
				cal_day   = w.day_in;
				cal_leap  = lp;
			end else begin
				bad = 1'b1;
			end
		end else begin
			lim = month_length(cal_month, cal_leap);
			if (cal_day < lim) begin
				cal_day = cal_day + 1'b1;
			end else begin
				cal_day = DAY_W'(1);
				if (cal_month >= LAST_MONTH) begin
					cal_month = MONTH_W'(1);
					cal_year  = cal_year + 1'b1;
					cal_leap  = is_leap(cal_year);
				end else begin
					cal_month = cal_month + 1'b1;
				end
			end
			bad = !year_fits(cal_year);
		end
		doy = cal_day;
		for (int k = 1; k < cal_month; k++)
			doy += month_length(MONTH_W'(k), cal_leap);
		r.year_out    = cal_year;
		r.month_out   = cal_month;
		r.day_out     = cal_day;
		r.day_of_year = DOY_W'(doy);
		r.leap_out    = cal_leap;
		r.status      = bad;
		return r;
	endfunction

	function automatic req_t date_word(logic c, int y, int m, int d);
		req_t w;
		w.cmd      = c;
		w.year_in  = YEAR_W'(y);
		w.month_in = MONTH_W'(m);
		w.day_in   = DAY_W'(d);
		return w;
	endfunction

	// Mostly well-formed loads near month ends plus ticks, with some raw noise.
	function automatic req_t random_word();
		int pick;
		int y;
		int m;
		int d;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return date_word(CMD_ADVANCE, $urandom_range(0, 9999), $urandom_range(0, 15),
				$urandom_range(0, 31));
		if (pick < 80) begin
			if (lo_year <= hi_year && $urandom_range(0, 99) < 85)
				y = $urandom_range(lo_year, hi_year);
			else
				y = $urandom_range(0, 9999);
			if ($urandom_range(0, 3) == 0)
				y = y - (y % 4);
			m = $urandom_range(1, 12);
			if ($urandom_range(0, 7) == 0)
				m = 12;
			len = month_length(MONTH_W'(m), is_leap(YEAR_W'(y)));
			if ($urandom_range(0, 2) == 0)
				d = $urandom_range(1, len);
			else
				d = $urandom_range(len - 1, len);
			return date_word(CMD_LOAD, y, m, d);
		end
		return date_word(CMD_LOAD, $urandom_range(0, 9999), $urandom_range(0, 15),
			$urandom_range(0, 31));
	endfunction

	task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	// Results are checked before the newly accepted command is predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				results_seen++;
				if (pending_dates.size() == 0) begin
					$error("result word with no command outstanding");
					errors++;
				end else begin
					oldest_date = pending_dates.pop_front();
					check_field("year_out", oldest_date.year_out, rsp.year_out);
					check_field("month_out", oldest_date.month_out, rsp.month_out);
					check_field("day_out", oldest_date.day_out, rsp.day_out);
					check_field("day_of_year", oldest_date.day_of_year, rsp.day_of_year);
					check_field("leap_out", oldest_date.leap_out, rsp.leap_out);
					check_field("status", oldest_date.status, rsp.status);
				end
			end
			if (req_valid && req_ready)
				pending_dates.push_back(calendar_apply(req));
		end
	end

	always @(posedge clk)
		rsp_ready <= !rsp_stall && ($urandom_range(0, 99) >= recv_pct);

	initial begin
		forever begin
			@(hold_go);
			rsp_stall = 1'b1;
			repeat (300) @(posedge clk);
			rsp_stall = 1'b0;
		end
	end

	// Called at a clock edge; returns at the edge that accepts the word, valid still high.
	task automatic send_word(req_t w);
		while ($urandom_range(0, 99) < send_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (!req_ready);
		words_sent++;
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_dates.size() != 0) @(posedge clk);
	endtask

	// Write one bound register, then read it back.
	task automatic cfg_write(logic idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_MIN_YEAR)
			lo_year = val[YEAR_W-1:0];
		else
			hi_year = val[YEAR_W-1:0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", 32'(val[YEAR_W-1:0]), prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_bounds(int lo, int hi);
		drain_results();
		cfg_write(REG_MIN_YEAR, 32'(lo));
		cfg_write(REG_MAX_YEAR, 32'(hi));
		bound_settings++;
	endtask

	task automatic test_reset_date();
		send_word(date_word(CMD_ADVANCE, 0, 0, 0));
	endtask

	task automatic test_load_rules();
		send_word(date_word(CMD_LOAD, 2000, 2, 29));
		send_word(date_word(CMD_LOAD, 1900, 2, 29));
		send_word(date_word(CMD_LOAD, 2024, 2, 29));
		send_word(date_word(CMD_LOAD, 2023, 2, 29));
		send_word(date_word(CMD_LOAD, 2023, 0, 10));
		send_word(date_word(CMD_LOAD, 2023, 13, 10));
		send_word(date_word(CMD_LOAD, 2023, 15, 31));
		send_word(date_word(CMD_LOAD, 2023, 6, 0));
		send_word(date_word(CMD_LOAD, 2023, 4, 31));
		send_word(date_word(CMD_LOAD, 0, 1, 1));
		send_word(date_word(CMD_LOAD, 9999, 12, 31));
		// Ticking past the upper bound still stores the new year.
		send_word(date_word(CMD_ADVANCE, 16383, 15, 31));
		send_word(date_word(CMD_ADVANCE, 0, 0, 0));
	endtask

	task automatic test_bound_edges();
		set_bounds(5000, 4000);
		send_word(date_word(CMD_LOAD, 4500, 6, 15));
		send_word(date_word(CMD_ADVANCE, 0, 0, 0));
		set_bounds(0, 0);
		send_word(date_word(CMD_LOAD, 0, 1, 1));
		send_word(date_word(CMD_ADVANCE, 0, 0, 0));
		// Raising the lower bound leaves the stored date alone but flags the next tick.
		set_bounds(10, 9999);
		send_word(date_word(CMD_ADVANCE, 0, 0, 0));
	endtask

	task automatic test_year_wrap();
		set_bounds(0, 16383);
		send_word(date_word(CMD_LOAD, 0, 2, 29));
		send_word(date_word(CMD_ADVANCE, 0, 0, 0));
		send_word(date_word(CMD_LOAD, 16383, 12, 31));
		send_word(date_word(CMD_ADVANCE, 0, 0, 0));
	endtask

	task automatic test_random_traffic(int lo, int hi, int n);
		set_bounds(lo, hi);
		repeat (n) send_word(random_word());
	endtask

	// A long receiver stall while words keep coming fills the result stage.
	task automatic test_backpressure();
		set_bounds(1995, 2005);
		repeat (100) send_word(random_word());
		-> hold_go;
		repeat (200) send_word(random_word());
	endtask

	initial begin
		cal_year  = RST_YEAR;
		cal_month = RST_MONTH;
		cal_day   = RST_DAY;
		cal_leap  = 1'b1;
		lo_year   = RST_MIN_YEAR;
		hi_year   = RST_MAX_YEAR;
		send_pct  = 31;
		recv_pct  = 61;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_date();
		test_load_rules();
		test_bound_edges();
		test_year_wrap();
		test_random_traffic(RST_MIN_YEAR, RST_MAX_YEAR, 300);
		test_random_traffic(0, 9999, 300);
		send_pct = 61;
		recv_pct = 31;
		test_backpressure();
		test_random_traffic($urandom_range(0, 9999), $urandom_range(0, 9999), 300);
		send_pct = 0;
		recv_pct = 0;
		test_random_traffic(9990, 9999, 300);
		test_random_traffic($urandom_range(0, 9999), $urandom_range(0, 9999), 300);

		req_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (pending_dates.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (pending_dates.size() != 0) begin
			$error("%0d result words never arrived", pending_dates.size());
			errors++;
		end

		$display("Sent %0d command words under %0d year-bound settings; checked %0d results.",
			words_sent, bound_settings, results_seen);
		$display("Covered load validation, leap rules, bound overruns, year wrap and stalls.");
		if (errors == 0)
			$display("calendar_date_counter_top_tb: clean");
		else
			$display("calendar_date_counter_top_tb: errors");
		$finish;
	end

endmodule
